FILE: design/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared types, register codes and reset values of the Lennard-Jones
// pair force accumulator.
// ----------------------------------------------------------------------------
package ljpf_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int CSR_IDX_W       = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_X_LOW  = 3'd0,
      CSR_BOX_X_HIGH = 3'd1,
      CSR_BOX_Y_LOW  = 3'd2,
      CSR_BOX_Y_HIGH = 3'd3,
      CSR_BOX_Z_LOW  = 3'd4,
      CSR_BOX_Z_HIGH = 3'd5,
      CSR_CUTOFF_SQ  = 3'd6
   } csr_index_type;

   localparam logic signed [31:0] BOX_LOW_RST   = 32'shFFE0_0000;
   localparam logic signed [31:0] BOX_HIGH_RST  = 32'sh0020_0000;
   localparam logic        [31:0] CUTOFF_SQ_RST = 32'd410042;

   typedef struct packed {
      logic signed [31:0] box_x_low;
      logic signed [31:0] box_x_high;
      logic signed [31:0] box_y_low;
      logic signed [31:0] box_y_high;
      logic signed [31:0] box_z_low;
      logic signed [31:0] box_z_high;
      logic        [31:0] cutoff_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] home_x;
      logic signed [31:0] home_y;
      logic signed [31:0] home_z;
      logic signed [31:0] neighbor_x;
      logic signed [31:0] neighbor_y;
      logic signed [31:0] neighbor_z;
      logic signed [31:0] coef_repulsive;
      logic signed [31:0] coef_attractive;
      logic               last_neighbor;
   } req_data_type;

   typedef struct packed {
      logic signed [47:0] pair_force_x;
      logic signed [47:0] pair_force_y;
      logic signed [47:0] pair_force_z;
      logic               within_cutoff;
      logic signed [47:0] total_force_x;
      logic signed [47:0] total_force_y;
      logic signed [47:0] total_force_z;
      logic               total_valid;
   } rsp_data_type;

   typedef struct packed {
      logic signed [31:0] d_x;
      logic signed [31:0] d_y;
      logic signed [31:0] d_z;
      logic        [63:0] rsq;
      logic               in_cut;
      logic signed [31:0] lj1;
      logic signed [31:0] lj2;
      logic               last;
   } pair_type;

endpackage

FILE: design/lj_pair_force_accumulator.sv
// ----------------------------------------------------------------------------
// lj_pair_force_accumulator
// Lennard-Jones pair force with minimum-image wrap and per-home totals.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  req_     in         push / full            req_data  (pair word)
//  rsp_     out        pop / empty            rsp_data  (force word)
//  csr_     in         valid / ready          csr_index, csr_data
//
//  Front per pair: capture, wrap, four square/accumulate steps, push.
//  Back outside the cutoff: pop, output. Inside: pop, reciprocal,
//  eight three-phase passes through the shared 32x32 multiplier, output;
//  the reciprocal is skipped and saturates when the raw rsq is at most 0x10000.
//  A pair queue between front and back and the result register decouple stalls.
//  Synchronous reset restores box bounds and cutoff and clears the totals.
// ----------------------------------------------------------------------------
module lj_pair_force_accumulator #(
   parameter int QUEUE_DEPTH = ljpf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  ljpf_pkg::req_data_type            req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output ljpf_pkg::rsp_data_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ljpf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                     csr_data
);
   import ljpf_pkg::*;

   cfg_type    cfg_ff;
   logic       q_push, q_full, q_pop, q_empty;
   pair_type   q_wdata, q_rdata;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_x_low  <= BOX_LOW_RST;
         cfg_ff.box_x_high <= BOX_HIGH_RST;
         cfg_ff.box_y_low  <= BOX_LOW_RST;
         cfg_ff.box_y_high <= BOX_HIGH_RST;
         cfg_ff.box_z_low  <= BOX_LOW_RST;
         cfg_ff.box_z_high <= BOX_HIGH_RST;
         cfg_ff.cutoff_sq  <= CUTOFF_SQ_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOX_X_LOW:  cfg_ff.box_x_low  <= csr_data;
            CSR_BOX_X_HIGH: cfg_ff.box_x_high <= csr_data;
            CSR_BOX_Y_LOW:  cfg_ff.box_y_low  <= csr_data;
            CSR_BOX_Y_HIGH: cfg_ff.box_y_high <= csr_data;
            CSR_BOX_Z_LOW:  cfg_ff.box_z_low  <= csr_data;
            CSR_BOX_Z_HIGH: cfg_ff.box_z_high <= csr_data;
            CSR_CUTOFF_SQ:  cfg_ff.cutoff_sq  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   ljpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (q_wdata)
   );

   ljpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   ljpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rdata),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: design/ljpf_front.sv
// ----------------------------------------------------------------------------
// ljpf_front
// Takes a pair word, wraps the separation into the box, sums the squared
// distance with one multiplier and classifies the pair against the cutoff.
// ----------------------------------------------------------------------------
module ljpf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  ljpf_pkg::cfg_type      cfg,
   input  logic                 req_push,
   output logic                 req_full,
   input  ljpf_pkg::req_data_type req_data,
   output logic                 q_push,
   input  logic                 q_full,
   output ljpf_pkg::pair_type     q_data
);
   import ljpf_pkg::*;

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_WRAP = 4'b0010,
      F_SQ   = 4'b0100,
      F_PUSH = 4'b1000
   } fstate_type;

   localparam logic signed [35:0] D_MAX = 36'sh0_7FFF_FFFF;
   localparam logic signed [35:0] D_MIN = 36'shF_8000_0000;

   function automatic logic signed [31:0] wrap_axis(
      input logic signed [31:0] home,
      input logic signed [31:0] nb,
      input logic signed [31:0] lo,
      input logic signed [31:0] hi
   );
      logic signed [35:0] lo_e;
      logic signed [35:0] hi_e;
      logic signed [35:0] len;
      logic signed [35:0] d;
      logic signed [31:0] r;
      lo_e = 36'(lo);
      hi_e = 36'(hi);
      len  = hi_e - lo_e;
      d    = 36'(home) - 36'(nb);
      if (d >= hi_e) begin
         d = d - len;
      end else if (d < lo_e) begin
         d = d + len;
      end
      if (d > D_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (d < D_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = d[31:0];
      end
      return r;
   endfunction

   fstate_type           state_ff, state_in;
   req_data_type         in_ff;
   logic signed [31:0]   dx_ff, dy_ff, dz_ff;
   logic [63:0]          rsq_ff, sq_ff;
   logic [1:0]           cnt_ff;
   logic signed [31:0]   d_sel;
   logic [31:0]          d_abs;
   logic [63:0]          sq_in;
   logic                 in_cut;

   assign req_full = (state_ff != F_IDLE);

   always_comb begin
      case (cnt_ff)
         2'd0:    d_sel = dx_ff;
         2'd1:    d_sel = dy_ff;
         default: d_sel = dz_ff;
      endcase
   end

   assign d_abs  = d_sel[31] ? (~d_sel + 32'd1) : d_sel;
   assign sq_in  = 64'(d_abs) * 64'(d_abs);
   assign in_cut = rsq_ff < {16'd0, cfg.cutoff_sq, 16'd0};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE:  if (req_push) state_in = F_WRAP;
         F_WRAP:  state_in = F_SQ;
         F_SQ:    if (cnt_ff == 2'd3) state_in = F_PUSH;
         F_PUSH:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req_push) begin
         in_ff <= req_data;
      end
      if (state_ff == F_WRAP) begin
         dx_ff  <= wrap_axis(in_ff.home_x, in_ff.neighbor_x, cfg.box_x_low, cfg.box_x_high);
         dy_ff  <= wrap_axis(in_ff.home_y, in_ff.neighbor_y, cfg.box_y_low, cfg.box_y_high);
         dz_ff  <= wrap_axis(in_ff.home_z, in_ff.neighbor_z, cfg.box_z_low, cfg.box_z_high);
         rsq_ff <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == F_SQ) begin
         sq_ff  <= sq_in;
         cnt_ff <= cnt_ff + 2'd1;
         if (cnt_ff != 2'd0) begin
            rsq_ff <= rsq_ff + sq_ff;
         end
      end
   end

   assign q_push        = (state_ff == F_PUSH) && !q_full;
   assign q_data.d_x    = dx_ff;
   assign q_data.d_y    = dy_ff;
   assign q_data.d_z    = dz_ff;
   assign q_data.rsq    = rsq_ff;
   assign q_data.in_cut = in_cut;
   assign q_data.lj1    = in_ff.coef_repulsive;
   assign q_data.lj2    = in_ff.coef_attractive;
   assign q_data.last   = in_ff.last_neighbor;

endmodule

FILE: design/ljpf_queue.sv
// ----------------------------------------------------------------------------
// ljpf_queue
// Short queue of classified pairs between the front and back parts.
// ----------------------------------------------------------------------------
module ljpf_queue #(
   parameter int DEPTH = ljpf_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ljpf_pkg::pair_type push_data,
   output logic             full,
   input  logic             pop,
   output ljpf_pkg::pair_type pop_data,
   output logic             empty
);
   import ljpf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pair_type           mem [DEPTH];
   logic [PTR_W-1:0]   wr_ff, rd_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

FILE: design/ljpf_back.sv
// ----------------------------------------------------------------------------
// ljpf_back
// Computes the pair force with a bit-serial reciprocal and one shared
// multiplier, accumulates the home totals and holds the result word.
// ----------------------------------------------------------------------------
module ljpf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  ljpf_pkg::pair_type     q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ljpf_pkg::rsp_data_type rsp_data
);
   import ljpf_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DIV  = 4'b0010,
      B_MUL  = 4'b0100,
      B_OUT  = 4'b1000
   } bstate_type;

   localparam logic [2:0] STEP_R4  = 3'd0;
   localparam logic [2:0] STEP_R6  = 3'd1;
   localparam logic [2:0] STEP_U   = 3'd2;
   localparam logic [2:0] STEP_FLJ = 3'd3;
   localparam logic [2:0] STEP_FF  = 3'd4;
   localparam logic [2:0] STEP_PFX = 3'd5;
   localparam logic [2:0] STEP_PFY = 3'd6;
   localparam logic [2:0] STEP_PFZ = 3'd7;

   localparam logic [1:0] PH_LO  = 2'd0;
   localparam logic [1:0] PH_HI  = 2'd1;
   localparam logic [1:0] PH_RES = 2'd2;

   localparam logic [47:0] SATV = 48'h7FFF_FFFF_FFFF;

   function automatic logic signed [47:0] sat50(input logic signed [49:0] v);
      logic signed [47:0] r;
      if (v > 50'sh0_7FFF_FFFF_FFFF) begin
         r = 48'sh7FFF_FFFF_FFFF;
      end else if (v < -50'sh0_7FFF_FFFF_FFFF) begin
         r = -48'sh7FFF_FFFF_FFFF;
      end else begin
         r = v[47:0];
      end
      return r;
   endfunction

   bstate_type           state_ff, state_in;
   pair_type             work_ff;
   logic [31:0]          quot_ff;
   logic [47:0]          rem_ff;
   logic [4:0]           div_cnt_ff;
   logic [2:0]           step_ff;
   logic [1:0]           phase_ff;
   logic [63:0]          prod_ff;
   logic [47:0]          lo_ff;
   logic [31:0]          r4_ff, r6_ff;
   logic signed [47:0]   u_ff, flj_ff, ff_ff;
   logic signed [47:0]   pfx_ff, pfy_ff, pfz_ff;
   logic signed [47:0]   sumx_ff, sumy_ff, sumz_ff;
   rsp_data_type         rsp_data_ff;
   logic                 rsp_valid_ff;

   logic signed [47:0]   a_val;
   logic [31:0]          b_val;
   logic [47:0]          a_mag;
   logic signed [31:0]   d_sel;
   logic [31:0]          d_abs;
   logic                 pf_step;
   logic                 res_neg;
   logic [31:0]          mul_a;
   logic [63:0]          mul_prod;
   logic [47:0]          hi_p;
   logic [48:0]          sum49;
   logic [47:0]          r_mag;
   logic signed [47:0]   res;
   logic [48:0]          rem_sh;
   logic                 ge;
   logic                 load;
   logic signed [47:0]   nsx, nsy, nsz;

   always_comb begin
      case (step_ff)
         STEP_PFY: d_sel = work_ff.d_y;
         STEP_PFZ: d_sel = work_ff.d_z;
         default:  d_sel = work_ff.d_x;
      endcase
   end

   assign d_abs   = d_sel[31] ? (~d_sel + 32'd1) : d_sel;
   assign pf_step = (step_ff == STEP_PFX) || (step_ff == STEP_PFY) ||
                    (step_ff == STEP_PFZ);

   always_comb begin
      case (step_ff)
         STEP_R4:  begin a_val = {16'd0, quot_ff};  b_val = quot_ff; end
         STEP_R6:  begin a_val = {16'd0, r4_ff};    b_val = quot_ff; end
         STEP_U:   begin a_val = 48'(work_ff.lj1);  b_val = r6_ff;   end
         STEP_FLJ: begin a_val = u_ff;              b_val = r6_ff;   end
         STEP_FF:  begin a_val = flj_ff;            b_val = quot_ff; end
         default:  begin a_val = ff_ff;             b_val = d_abs;   end
      endcase
   end

   assign a_mag    = a_val[47] ? 48'(-a_val) : a_val;
   assign res_neg  = a_val[47] ^ (pf_step & d_sel[31]);
   assign mul_a    = (phase_ff == PH_LO) ? a_mag[31:0] : {16'd0, a_mag[47:32]};
   assign mul_prod = 64'(mul_a) * 64'(b_val);

   assign hi_p  = prod_ff[47:0];
   assign sum49 = (49'(hi_p[31:0]) << 16) + 49'(lo_ff);
   assign r_mag = ((hi_p > 48'h0000_7FFF_FFFF) || (sum49 > 49'(SATV))) ? SATV : sum49[47:0];
   assign res   = res_neg ? -$signed(r_mag) : $signed(r_mag);

   assign rem_sh = {rem_ff, 1'b0};
   assign ge     = rem_sh >= {1'b0, work_ff.rsq[47:0]};

   assign q_pop     = (state_ff == B_IDLE) && !q_empty;
   assign load      = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign nsx = work_ff.in_cut ? sat50(50'(sumx_ff) + 50'(pfx_ff)) : sumx_ff;
   assign nsy = work_ff.in_cut ? sat50(50'(sumy_ff) + 50'(pfy_ff)) : sumy_ff;
   assign nsz = work_ff.in_cut ? sat50(50'(sumz_ff) + 50'(pfz_ff)) : sumz_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (!q_data.in_cut) begin
                  state_in = B_OUT;
               end else if (q_data.rsq[47:0] <= 48'h0_0001_0000) begin
                  state_in = B_MUL;
               end else begin
                  state_in = B_DIV;
               end
            end
         end
         B_DIV:   if (div_cnt_ff == 5'd31) state_in = B_MUL;
         B_MUL:   if (phase_ff == PH_RES && step_ff == STEP_PFZ) state_in = B_OUT;
         B_OUT:   if (load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
         sumz_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
            sumx_ff      <= work_ff.last ? '0 : nsx;
            sumy_ff      <= work_ff.last ? '0 : nsy;
            sumz_ff      <= work_ff.last ? '0 : nsz;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_prod;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               work_ff    <= q_data;
               quot_ff    <= 32'hFFFF_FFFF;
               rem_ff     <= 48'h0_0001_0000;
               div_cnt_ff <= '0;
               step_ff    <= STEP_R4;
               phase_ff   <= PH_LO;
               pfx_ff     <= '0;
               pfy_ff     <= '0;
               pfz_ff     <= '0;
            end
         end
         B_DIV: begin
            rem_ff     <= ge ? 48'(rem_sh - {1'b0, work_ff.rsq[47:0]}) : rem_sh[47:0];
            quot_ff    <= {quot_ff[30:0], ge};
            div_cnt_ff <= div_cnt_ff + 5'd1;
         end
         B_MUL: begin
            case (phase_ff)
               PH_LO: phase_ff <= PH_HI;
               PH_HI: begin
                  lo_ff    <= prod_ff[63:16];
                  phase_ff <= PH_RES;
               end
               default: begin
                  phase_ff <= PH_LO;
                  step_ff  <= step_ff + 3'd1;
                  case (step_ff)
                     STEP_R4:  r4_ff  <= (r_mag > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : r_mag[31:0];
                     STEP_R6:  r6_ff  <= (r_mag > 48'h0000_FFFF_FFFF) ? 32'hFFFF_FFFF : r_mag[31:0];
                     STEP_U:   u_ff   <= sat50(50'(res) - 50'(work_ff.lj2));
                     STEP_FLJ: flj_ff <= res;
                     STEP_FF:  ff_ff  <= res;
                     STEP_PFX: pfx_ff <= res;
                     STEP_PFY: pfy_ff <= res;
                     default:  pfz_ff <= res;
                  endcase
               end
            endcase
         end
         default: begin
         end
      endcase
      if (load) begin
         rsp_data_ff.pair_force_x  <= pfx_ff;
         rsp_data_ff.pair_force_y  <= pfy_ff;
         rsp_data_ff.pair_force_z  <= pfz_ff;
         rsp_data_ff.within_cutoff <= work_ff.in_cut;
         rsp_data_ff.total_force_x <= work_ff.last ? nsx : '0;
         rsp_data_ff.total_force_y <= work_ff.last ? nsy : '0;
         rsp_data_ff.total_force_z <= work_ff.last ? nsz : '0;
         rsp_data_ff.total_valid   <= work_ff.last;
      end
   end

`ifndef SYNTH
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (load && !work_ff.in_cut) |=> (rsp_data_ff.pair_force_x == '0 &&
      rsp_data_ff.pair_force_y == '0 && rsp_data_ff.pair_force_z == '0))
      else $error("nonzero force outside cutoff");
   a_totals_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.total_valid) |-> (rsp_data_ff.total_force_x == '0 &&
      rsp_data_ff.total_force_y == '0 && rsp_data_ff.total_force_z == '0))
      else $error("totals shown on a non-final word");
   a_div_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV || state_ff == B_MUL) |-> work_ff.in_cut)
      else $error("force path entered for a pair outside cutoff");
`endif

endmodule
